FILE: rtl/core/command_frame_builder_crc16_assert.svh
// Assertion macros used by the frame builder checker.
`ifndef COMMAND_FRAME_BUILDER_CRC16_ASSERT_SVH
`define COMMAND_FRAME_BUILDER_CRC16_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CFB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame builder check failed");

// Next-cycle implication, disabled during reset.
`define CFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame builder check failed");

`endif

FILE: rtl/core/cfb_pkg.sv
// Package: types and constants of the command frame builder.
package cfb_pkg;

    localparam int MaxDataBytesDef = 8;
    localparam int ByteW           = 8;
    localparam int IdxW            = 4;
    localparam int CountW          = 4;
    localparam int CrcW            = 16;

    localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
    localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    // Control from the sequencer to the shared CRC unit
    typedef struct packed {
        logic             init;
        logic             update;
        logic [ByteW-1:0] data;
    } t_crc_ctrl;

endpackage

FILE: rtl/core/cfb_crc_unit.sv
// Shared CRC-16 unit: folds one frame byte per cycle into the running CRC while update is set.
module cfb_crc_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cfb_pkg::t_crc_ctrl          i_ctrl,
    output logic [cfb_pkg::CrcW-1:0]    o_crc
);

    logic [cfb_pkg::CrcW-1:0] r_crc;
    logic [cfb_pkg::CrcW-1:0] n_crc;

    // Shift the byte in LSB first, eight reflected polynomial steps
    always_comb begin
        logic [cfb_pkg::CrcW-1:0] v;
        v = r_crc ^ {8'h00, i_ctrl.data};
        for (int k = 0; k < cfb_pkg::ByteW; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ cfb_pkg::CrcPoly;
            end else begin
                v = v >> 1;
            end
        end
        n_crc = v;
    end

    // Load the seed at frame start, advance on each covered byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= cfb_pkg::CrcInit;
        end else if (i_ctrl.init) begin
            r_crc <= cfb_pkg::CrcInit;
        end else if (i_ctrl.update) begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

FILE: rtl/core/cfb_seq.sv
// Frame sequencer: latches a request, picks each frame byte, drives the output register.
module cfb_seq #(
    parameter int MAX_DATA_BYTES = cfb_pkg::MaxDataBytesDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_packet_type,
    input  logic                           i_use_device_addr,
    input  logic [6:0]                     i_device_addr,
    input  logic [15:0]                    i_reg_addr,
    input  logic [8*MAX_DATA_BYTES-1:0]    i_payload,
    input  logic [cfb_pkg::CountW-1:0]     i_byte_count,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [cfb_pkg::ByteW-1:0]      o_frame_byte,
    output logic [cfb_pkg::IdxW-1:0]       o_byte_index,
    output logic                           o_last_byte,
    output cfb_pkg::t_crc_ctrl             o_crc_ctrl,
    input  logic [cfb_pkg::CrcW-1:0]       i_crc
);

    localparam int PayW = 8 * MAX_DATA_BYTES;

    cfb_pkg::t_seq_state r_state;
    cfb_pkg::t_seq_state n_state;

    logic [cfb_pkg::IdxW-1:0]  r_pos;
    logic [cfb_pkg::IdxW-1:0]  r_crc_pos;
    logic                      r_use_dev;
    logic [7:0]                r_type;
    logic [6:0]                r_dev;
    logic [15:0]               r_reg;
    logic [PayW-1:0]           r_payload;

    logic                      r_out_valid;
    logic [cfb_pkg::ByteW-1:0] r_frame_byte;
    logic [cfb_pkg::IdxW-1:0]  r_byte_index;
    logic                      r_last_byte;

    logic                      accept;
    logic                      count_ok;
    logic                      load;
    logic                      is_data;
    logic                      is_last;
    logic [cfb_pkg::IdxW-1:0]  hdr_len;
    logic [cfb_pkg::ByteW-1:0] sel_byte;

    assign count_ok = (i_byte_count != '0) &&
                      (i_byte_count <= cfb_pkg::CountW'(MAX_DATA_BYTES));
    assign hdr_len  = r_use_dev ? cfb_pkg::IdxW'(4) : cfb_pkg::IdxW'(3);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfb_pkg::SEQ_IDLE: begin
                if (i_valid && count_ok) begin
                    n_state = cfb_pkg::SEQ_RUN;
                end
            end
            cfb_pkg::SEQ_RUN: begin
                if (load && is_last) begin
                    n_state = cfb_pkg::SEQ_IDLE;
                end
            end
            default: n_state = cfb_pkg::SEQ_IDLE;
        endcase
    end

    // Handshake and load strobes
    always_comb begin
        o_stall = (r_state != cfb_pkg::SEQ_IDLE);
        accept  = i_valid && (r_state == cfb_pkg::SEQ_IDLE);
        load    = (r_state == cfb_pkg::SEQ_RUN) && (!r_out_valid || !i_stall);
        is_data = (r_pos < r_crc_pos);
        is_last = (r_pos == r_crc_pos + cfb_pkg::IdxW'(1));
    end

    // Pick the byte for the current frame position
    always_comb begin
        priority if (r_pos == '0) begin
            sel_byte = r_type;
        end else if (r_use_dev && r_pos == cfb_pkg::IdxW'(1)) begin
            sel_byte = {1'b0, r_dev};
        end else if (r_pos == hdr_len - cfb_pkg::IdxW'(2)) begin
            sel_byte = r_reg[15:8];
        end else if (r_pos == hdr_len - cfb_pkg::IdxW'(1)) begin
            sel_byte = r_reg[7:0];
        end else if (is_data) begin
            sel_byte = r_payload[7:0];
        end else if (r_pos == r_crc_pos) begin
            sel_byte = i_crc[7:0];
        end else begin
            sel_byte = i_crc[15:8];
        end
    end

    // CRC unit control
    always_comb begin
        o_crc_ctrl.init   = accept;
        o_crc_ctrl.update = load && is_data;
        o_crc_ctrl.data   = sel_byte;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfb_pkg::SEQ_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Latch the request, advance position and payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos     <= '0;
            r_use_dev <= i_use_device_addr;
            r_type    <= i_packet_type;
            r_dev     <= i_device_addr;
            r_reg     <= i_reg_addr;
            r_payload <= i_payload;
            r_crc_pos <= (i_use_device_addr ? cfb_pkg::IdxW'(4) : cfb_pkg::IdxW'(3))
                         + cfb_pkg::IdxW'(i_byte_count);
        end else if (load) begin
            r_pos <= r_pos + cfb_pkg::IdxW'(1);
            if (is_data && r_pos >= hdr_len) begin
                r_payload <= r_payload >> 8;
            end
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_frame_byte <= sel_byte;
            r_byte_index <= r_pos;
            r_last_byte  <= is_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_frame_byte;
    assign o_byte_index = r_byte_index;
    assign o_last_byte  = r_last_byte;

endmodule

FILE: rtl/core/command_frame_builder_crc16.sv
// Top level of the command frame builder with CRC-16.
// Takes one command request and emits its frame one byte per transaction: packet type,
// optional device address, register address high then low, the data bytes, then the
// CRC-16 (reflected 0xA001, seed 0xFFFF) low byte then high byte. A frame is 6 to 14
// bytes, and the block produces one byte per cycle while the output is not stalled. The
// single shared CRC unit folds in one header or data byte per cycle as each is loaded.
// The input is stalled until the last byte of a frame is loaded into the output
// register. A request whose byte count is 0 or above MAX_DATA_BYTES is taken and
// dropped without output.
module command_frame_builder_crc16 #(
    parameter int MAX_DATA_BYTES = cfb_pkg::MaxDataBytesDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_packet_type,
    input  logic                           i_use_device_addr,
    input  logic [6:0]                     i_device_addr,
    input  logic [15:0]                    i_reg_addr,
    input  logic [8*MAX_DATA_BYTES-1:0]    i_payload,
    input  logic [3:0]                     i_byte_count,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_frame_byte,
    output logic [3:0]                     o_byte_index,
    output logic                           o_last_byte
);

    cfb_pkg::t_crc_ctrl       crc_ctrl;
    logic [cfb_pkg::CrcW-1:0] crc;

    // Sequencer and output register
    cfb_seq #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_packet_type     (i_packet_type),
        .i_use_device_addr (i_use_device_addr),
        .i_device_addr     (i_device_addr),
        .i_reg_addr        (i_reg_addr),
        .i_payload         (i_payload),
        .i_byte_count      (i_byte_count),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_frame_byte      (o_frame_byte),
        .o_byte_index      (o_byte_index),
        .o_last_byte       (o_last_byte),
        .o_crc_ctrl        (crc_ctrl),
        .i_crc             (crc)
    );

    // Shared CRC unit
    cfb_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (crc_ctrl),
        .o_crc   (crc)
    );

endmodule

FILE: rtl/core/cfb_checker.sv
// Port-level checker for the frame builder, bound to the top level.
`include "command_frame_builder_crc16_assert.svh"

module cfb_checker #(
    parameter int MAX_DATA_BYTES = cfb_pkg::MaxDataBytesDef
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [3:0] i_byte_count,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_frame_byte,
    input logic [3:0] o_byte_index,
    input logic       o_last_byte
);

    logic in_acc;
    logic cnt_ok;

    assign in_acc = i_valid && !o_stall;
    assign cnt_ok = (i_byte_count != 4'd0) && (i_byte_count <= 4'(MAX_DATA_BYTES));

    // A stalled output transaction holds
    `CFB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_frame_byte) && $stable(o_byte_index) && $stable(o_last_byte))
    // A frame is never shorter than six bytes
    `CFB_ASSERT_NOW(a_min_len, i_clk, i_rst_n, o_valid && o_last_byte, o_byte_index >= 4'd5)
    // Bytes of one frame follow without gaps
    `CFB_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, o_valid && !i_stall && !o_last_byte, o_valid)
    // A good request blocks the input while its frame runs
    `CFB_ASSERT_NEXT(a_busy, i_clk, i_rst_n, in_acc && cnt_ok, o_stall)
    // A bad request is dropped at once
    `CFB_ASSERT_NEXT(a_drop, i_clk, i_rst_n, in_acc && !cnt_ok, !o_stall)

endmodule

bind command_frame_builder_crc16 cfb_checker #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
) u_cfb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_byte_count (i_byte_count),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_frame_byte (o_frame_byte),
    .o_byte_index (o_byte_index),
    .o_last_byte  (o_last_byte)
);
